// ===== hw/rtl/lcdns_pkg.sv =====
// package with payload types, request codes and init sequence tables for the lcd nibble sequencer
`timescale 1ns / 1ps
`default_nettype none

package lcdns_pkg;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] value;
        logic [1:0] row;
        logic [5:0] column;
    } lcdns_in_t;

    typedef struct packed {
        logic        reg_select;
        logic [3:0]  nibble;
        logic [16:0] wait_before_us;
        logic        last;
    } lcdns_out_t;

    // one classified request as held in the queue
    typedef struct packed {
        logic       is_init;
        logic       reg_select;
        logic [7:0] data_byte;
    } lcdns_cmd_t;

    localparam logic [2:0] MODE_DATA    = 3'd0;
    localparam logic [2:0] MODE_COMMAND = 3'd1;
    localparam logic [2:0] MODE_CURSOR  = 3'd2;
    localparam logic [2:0] MODE_CLEAR   = 3'd3;
    localparam logic [2:0] MODE_INIT    = 3'd4;

    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [6:0] ADDR_MASK     = 7'h7F;

    localparam logic [16:0] FUNC_SET_EXTRA_US = 17'd1000;
    localparam logic [15:0] BUSY_WAIT_RESET   = 16'd5000;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] RESET_NIB_STEPS = 4'd4;
    localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 4'd11;

    function automatic logic [6:0] row_offset(input logic [1:0] row);
        logic [6:0] off;
        unique case (row)
            2'd0:    off = 7'h00;
            2'd1:    off = 7'h40;
            2'd2:    off = 7'h14;
            default: off = 7'h54;
        endcase
        return off;
    endfunction

    function automatic logic [3:0] reset_nibble(input logic [1:0] idx);
        return (idx == 2'd3) ? 4'h2 : 4'h3;
    endfunction

    function automatic logic [16:0] reset_extra_us(input logic [1:0] idx);
        logic [16:0] us;
        unique case (idx)
            2'd0:    us = 17'd20000;
            2'd1:    us = 17'd10000;
            default: us = 17'd1000;
        endcase
        return us;
    endfunction

    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h28;
            2'd1:    c = 8'h0C;
            2'd2:    c = 8'h01;
            default: c = 8'h06;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lcdns_front.sv =====
// front end: classifies requests into byte or init entries for the queue
`timescale 1ns / 1ps
`default_nettype none

module lcdns_front (
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire lcdns_pkg::lcdns_in_t in_data,
    input  wire logic                q_full,
    output logic                     q_push,
    output lcdns_pkg::lcdns_cmd_t    q_data
);
    import lcdns_pkg::*;

    logic       known;
    logic [6:0] addr;

    assign addr     = (row_offset(in_data.row) + {1'b0, in_data.column}) & ADDR_MASK;
    assign in_stall = q_full;

    always_comb
    begin
        known              = 1'b1;
        q_data.is_init     = 1'b0;
        q_data.reg_select  = RS_COMMAND;
        q_data.data_byte   = in_data.value;
        unique case (in_data.mode)
            MODE_DATA:    q_data.reg_select = RS_DATA;
            MODE_COMMAND: q_data.data_byte  = in_data.value;
            MODE_CURSOR:  q_data.data_byte  = CMD_SET_DDRAM | {1'b0, addr};
            MODE_CLEAR:   q_data.data_byte  = CMD_CLEAR;
            MODE_INIT:    q_data.is_init    = 1'b1;
            default:      known             = 1'b0;
        endcase
    end

    // unknown modes are taken and dropped
    assign q_push = in_valid && !q_full && known;

endmodule

`default_nettype wire

// ===== hw/rtl/lcdns_queue.sv =====
// small fifo between front and back
`timescale 1ns / 1ps
`default_nettype none

module lcdns_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire lcdns_pkg::lcdns_cmd_t push_data,
    input  wire logic                  pop,
    output logic                       full,
    output logic                       not_empty,
    output lcdns_pkg::lcdns_cmd_t      head
);
    import lcdns_pkg::*;

    lcdns_cmd_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lcdns_back.sv =====
// back end: steps through the nibble transfers of the queue head into the output register
`timescale 1ns / 1ps
`default_nettype none

module lcdns_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [15:0]           busy_wait_us,
    input  wire logic                  q_not_empty,
    input  wire lcdns_pkg::lcdns_cmd_t q_head,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output lcdns_pkg::lcdns_out_t      out_data
);
    import lcdns_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    lcdns_out_t        out_data_reg;
    lcdns_out_t        xfer;
    logic              load;
    logic              final_step;
    logic [16:0]       busy_ext;
    logic [1:0]        cmd_idx;
    logic [7:0]        cur_byte;
    logic [16:0]       hi_extra;

    assign busy_ext = {1'b0, busy_wait_us};
    assign load     = q_not_empty && (!out_valid_reg || !out_stall);
    assign cmd_idx  = step_reg[2:1] - 2'd2;

    always_comb
    begin
        xfer            = '0;
        xfer.reg_select = q_head.reg_select;
        cur_byte        = q_head.data_byte;
        hi_extra        = '0;
        final_step      = 1'b0;
        if (q_head.is_init)
        begin
            xfer.reg_select = RS_COMMAND;
            cur_byte        = init_cmd(cmd_idx);
            hi_extra        = (cmd_idx == 2'd0) ? FUNC_SET_EXTRA_US : '0;
            final_step      = (step_reg == INIT_LAST_STEP);
            if (step_reg < RESET_NIB_STEPS)
            begin
                // reset nibbles go out alone
                xfer.nibble         = reset_nibble(step_reg[1:0]);
                xfer.wait_before_us = reset_extra_us(step_reg[1:0]) + busy_ext;
            end
            else if (!step_reg[0])
            begin
                xfer.nibble         = cur_byte[7:4];
                xfer.wait_before_us = hi_extra + busy_ext;
            end
            else
            begin
                xfer.nibble         = cur_byte[3:0];
                xfer.wait_before_us = '0;
            end
        end
        else
        begin
            final_step = step_reg[0];
            if (!step_reg[0])
            begin
                xfer.nibble         = cur_byte[7:4];
                xfer.wait_before_us = busy_ext;
            end
            else
            begin
                xfer.nibble         = cur_byte[3:0];
                xfer.wait_before_us = '0;
            end
        end
        xfer.last = final_step;
    end

    assign q_pop = load && final_step;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            step_next      = final_step ? '0 : step_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= xfer;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/char_lcd_nibble_sequencer_unit.sv =====
// top level of the character lcd nibble sequencer
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake          payload
// in       in   in_valid/in_stall   lcdns_in_t   (mode, value, row, column)
// out      out  out_valid/out_stall lcdns_out_t  (reg_select, nibble, wait_before_us, last)
// cfg      in   cfg_valid/cfg_ready cfg_data     (busy_wait_us)
//
// the back end emits one transfer per cycle from the queue head when not stalled: a byte
// request is two nibble transfers, initialize twelve, unknown modes are dropped in the front
// a two-entry queue lets the front take requests while the back is busy
// out_stall holds the output register and the step counter; in_stall is queue full
// reset empties queue and output, busy_wait_us returns to 5000

module char_lcd_nibble_sequencer_unit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire lcdns_pkg::lcdns_in_t  in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output lcdns_pkg::lcdns_out_t      out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [15:0]           cfg_data
);
    import lcdns_pkg::*;

    logic [15:0] busy_wait_reg;
    logic        q_full, q_push, q_pop, q_not_empty;
    lcdns_cmd_t  q_in, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_wait_reg <= BUSY_WAIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            busy_wait_reg <= cfg_data;
        end
    end

    lcdns_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    lcdns_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    lcdns_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .busy_wait_us (busy_wait_reg),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

endmodule

`default_nettype wire
